>>> rtl/schte_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package schte_pkg;

   // Clause and variable table sizes
   localparam int MAX_LITERALS  = 16;
   localparam int MAX_VARIABLES = 256;
   localparam int QUEUE_DEPTH   = 2;

   // Field widths
   localparam int OP_W     = 3;
   localparam int LIT_W    = 9;
   localparam int VAR_W    = 8;
   localparam int LEVEL_W  = 8;
   localparam int PTR_W    = 5;
   localparam int STATUS_W = 2;

   // Derived storage widths
   localparam int LIT_AW = $clog2(MAX_LITERALS);
   localparam int VAR_AW = $clog2(MAX_VARIABLES);
   localparam int VAR_DW = 1 + LEVEL_W;
   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // Operation codes on the request channel
   localparam logic [OP_W-1:0] OP_LOAD     = 3'd0;
   localparam logic [OP_W-1:0] OP_ASSIGN   = 3'd1;
   localparam logic [OP_W-1:0] OP_UNASSIGN = 3'd2;
   localparam logic [OP_W-1:0] OP_UPDATE   = 3'd3;
   localparam logic [OP_W-1:0] OP_ROLLBACK = 3'd4;

   // Clause status codes
   localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd0;
   localparam logic [STATUS_W-1:0] ST_UNIT    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_SAT     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_UNSAT   = 2'd3;

   typedef enum logic [2:0] {
      KIND_LOAD,
      KIND_ASSIGN,
      KIND_UNASSIGN,
      KIND_UPDATE,
      KIND_ROLLBACK,
      KIND_NONE
   } op_kind_type;

   typedef struct packed {
      op_kind_type                kind;
      logic                       start_new;
      logic signed [LIT_W-1:0]    literal;
      logic [VAR_W-1:0]           variable;
      logic                       var_ok;
      logic                       truth;
      logic [LEVEL_W-1:0]         level;
      logic [PTR_W-1:0]           head_in;
      logic [PTR_W-1:0]           tail_in;
      logic [STATUS_W-1:0]        status_in;
   } cmd_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN_HEAD,
      S_SCAN_TAIL,
      S_END_HEAD,
      S_END_TAIL,
      S_CLASSIFY,
      S_UNIT,
      S_LIT_WAIT,
      S_VAR_WAIT,
      S_REPLY
   } state_type;

   typedef enum logic [2:0] {
      PR_HEAD,
      PR_TAIL,
      PR_END_HEAD,
      PR_END_TAIL,
      PR_UNIT
   } probe_type;

endpackage

`default_nettype wire

>>> rtl/schte_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module schte_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

>>> rtl/schte_front.sv
`timescale 1ns / 1ps
`default_nettype none

module schte_front
   import schte_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [OP_W-1:0]             req_operation,
   input  wire logic                        req_start_new,
   input  wire logic signed [LIT_W-1:0]     req_literal,
   input  wire logic [VAR_W-1:0]            req_variable,
   input  wire logic                        req_truth,
   input  wire logic [LEVEL_W-1:0]          req_level,
   input  wire logic [PTR_W-1:0]            req_head_in,
   input  wire logic [PTR_W-1:0]            req_tail_in,
   input  wire logic [STATUS_W-1:0]         req_status_in,
   output cmd_type                          cmd,
   output logic                             cmd_valid,
   input  wire logic                        cmd_pop
);

   cmd_type             q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   q_count_ff, q_count_in;
   cmd_type             decoded;
   logic                push;
   logic                pop;

   // Classify the incoming item
   always_comb begin
      decoded.start_new = req_start_new;
      decoded.literal   = req_literal;
      decoded.variable  = req_variable;
      decoded.var_ok    = int'(req_variable) < MAX_VARIABLES;
      decoded.truth     = req_truth;
      decoded.level     = req_level;
      decoded.head_in   = req_head_in;
      decoded.tail_in   = req_tail_in;
      decoded.status_in = req_status_in;
      unique case (req_operation)
         OP_LOAD:     decoded.kind = KIND_LOAD;
         OP_ASSIGN:   decoded.kind = KIND_ASSIGN;
         OP_UNASSIGN: decoded.kind = KIND_UNASSIGN;
         OP_UPDATE:   decoded.kind = KIND_UPDATE;
         OP_ROLLBACK: decoded.kind = KIND_ROLLBACK;
         default:     decoded.kind = KIND_NONE;
      endcase
   end

   assign req_stall = (q_count_ff == QCNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (q_count_ff != '0);
   assign pop       = cmd_pop && cmd_valid;
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      q_count_in = q_count_ff;
      if (push) begin
         wr_ptr_in = (int'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (int'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         q_count_in = q_count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         q_count_in = q_count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         q_count_ff <= '0;
      end else begin
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         q_count_ff <= q_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

`default_nettype wire

>>> rtl/schte_back.sv
`timescale 1ns / 1ps
`default_nettype none

module schte_back
   import schte_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire cmd_type                     cmd,
   input  wire logic                        cmd_valid,
   output logic                             cmd_pop,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [STATUS_W-1:0]              rsp_status,
   output logic signed [LIT_W-1:0]          rsp_unit_literal,
   output logic [PTR_W-1:0]                 rsp_head,
   output logic [PTR_W-1:0]                 rsp_tail
);

   state_type                  state_ff, state_in;
   probe_type                  probe_ff, probe_in;
   logic [PTR_W-1:0]           count_ff, count_in;
   logic [PTR_W-1:0]           head_ptr_ff, head_ptr_in;
   logic [PTR_W-1:0]           tail_ptr_ff, tail_ptr_in;
   logic [STATUS_W-1:0]        clause_status_ff, clause_status_in;
   logic [MAX_VARIABLES-1:0]   var_valid_ff, var_valid_in;
   logic [LIT_W-1:0]           lit_ff, lit_in;
   logic [LIT_W-1:0]           ulit_ff, ulit_in;
   logic                       vld_rd_ff, vld_rd_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]        rsp_status_ff;
   logic [LIT_W-1:0]           rsp_ulit_ff;
   logic [PTR_W-1:0]           rsp_head_ff;
   logic [PTR_W-1:0]           rsp_tail_ff;

   logic                       lit_wr_en;
   logic [LIT_AW-1:0]          lit_wr_addr;
   logic [LIT_W-1:0]           lit_wr_data_w;
   logic [LIT_AW-1:0]          lit_rd_addr;
   logic [LIT_W-1:0]           lit_rd_data;
   logic                       var_wr_en;
   logic [VAR_AW-1:0]          var_wr_addr;
   logic [VAR_DW-1:0]          var_wr_data;
   logic [VAR_AW-1:0]          var_rd_addr;
   logic [VAR_DW-1:0]          var_rd_data;

   logic [LIT_W-1:0]           lit_mag;
   logic                       lit_in_table;
   logic [PTR_W-1:0]           load_base;
   logic                       settled;
   logic                       lit_true;
   logic                       rsp_load;

   schte_ram #(.WIDTH(LIT_W), .DEPTH(MAX_LITERALS)) u_lit_ram (
      .clock   (clock),
      .wr_en   (lit_wr_en),
      .wr_addr (lit_wr_addr),
      .wr_data (lit_wr_data_w),
      .rd_addr (lit_rd_addr),
      .rd_data (lit_rd_data)
   );

   assign lit_wr_data_w = cmd.literal;

   schte_ram #(.WIDTH(VAR_DW), .DEPTH(MAX_VARIABLES)) u_var_ram (
      .clock   (clock),
      .wr_en   (var_wr_en),
      .wr_addr (var_wr_addr),
      .wr_data (var_wr_data),
      .rd_addr (var_rd_addr),
      .rd_data (var_rd_data)
   );

   // Variable lookup of the literal just read from the clause store
   assign lit_mag      = lit_rd_data[LIT_W-1] ? LIT_W'(~lit_rd_data + LIT_W'(1)) : lit_rd_data;
   assign lit_in_table = int'(lit_mag) < MAX_VARIABLES;
   assign var_rd_addr  = VAR_AW'(lit_mag);
   assign vld_rd_in    = lit_in_table && var_valid_ff[var_rd_addr];

   // Entry without a valid bit reads as unassigned and undecided
   assign settled  = vld_rd_ff && (var_rd_data[LEVEL_W-1:0] <= cmd.level);
   assign lit_true = vld_rd_ff && (lit_ff != '0)
                     && (lit_ff[LIT_W-1] ? !var_rd_data[VAR_DW-1] : var_rd_data[VAR_DW-1]);

   assign load_base = cmd.start_new ? '0 : count_ff;

   always_comb begin
      state_in         = state_ff;
      probe_in         = probe_ff;
      count_in         = count_ff;
      head_ptr_in      = head_ptr_ff;
      tail_ptr_in      = tail_ptr_ff;
      clause_status_in = clause_status_ff;
      var_valid_in     = var_valid_ff;
      lit_in           = lit_ff;
      ulit_in          = ulit_ff;
      lit_wr_en        = 1'b0;
      lit_wr_addr      = load_base[LIT_AW-1:0];
      lit_rd_addr      = head_ptr_ff[LIT_AW-1:0];
      var_wr_en        = 1'b0;
      var_wr_addr      = VAR_AW'(cmd.variable);
      var_wr_data      = {cmd.truth, cmd.level};
      cmd_pop          = 1'b0;
      rsp_load         = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               state_in = S_UNIT;
               unique case (cmd.kind)
                  KIND_LOAD: begin
                     if (load_base < PTR_W'(MAX_LITERALS)) begin
                        lit_wr_en        = 1'b1;
                        count_in         = load_base + PTR_W'(1);
                        head_ptr_in      = '0;
                        tail_ptr_in      = load_base + PTR_W'(1);
                        clause_status_in = ST_UNKNOWN;
                     end
                  end
                  KIND_ASSIGN: begin
                     if (cmd.var_ok) begin
                        var_wr_en                 = 1'b1;
                        var_valid_in[var_wr_addr] = 1'b1;
                     end
                  end
                  KIND_UNASSIGN: begin
                     if (cmd.var_ok) begin
                        var_valid_in[var_wr_addr] = 1'b0;
                     end
                  end
                  KIND_UPDATE: begin
                     if (clause_status_ff != ST_SAT && clause_status_ff != ST_UNSAT) begin
                        state_in = S_SCAN_HEAD;
                     end
                  end
                  KIND_ROLLBACK: begin
                     head_ptr_in      = (cmd.head_in > count_ff) ? count_ff : cmd.head_in;
                     tail_ptr_in      = (cmd.tail_in > count_ff) ? count_ff : cmd.tail_in;
                     clause_status_in = cmd.status_in;
                  end
                  KIND_NONE: begin
                  end
               endcase
            end
         end

         S_SCAN_HEAD: begin
            if (head_ptr_ff < tail_ptr_ff) begin
               lit_rd_addr = head_ptr_ff[LIT_AW-1:0];
               probe_in    = PR_HEAD;
               state_in    = S_LIT_WAIT;
            end else begin
               state_in = S_SCAN_TAIL;
            end
         end

         S_SCAN_TAIL: begin
            if (head_ptr_ff < tail_ptr_ff) begin
               lit_rd_addr = LIT_AW'(tail_ptr_ff - PTR_W'(1));
               probe_in    = PR_TAIL;
               state_in    = S_LIT_WAIT;
            end else begin
               state_in = S_END_HEAD;
            end
         end

         // Recheck the literal just behind the head
         S_END_HEAD: begin
            if (head_ptr_ff != '0) begin
               lit_rd_addr = LIT_AW'(head_ptr_ff - PTR_W'(1));
               probe_in    = PR_END_HEAD;
               state_in    = S_LIT_WAIT;
            end else begin
               state_in = S_END_TAIL;
            end
         end

         // Recheck the literal at the tail
         S_END_TAIL: begin
            if (tail_ptr_ff < count_ff) begin
               lit_rd_addr = tail_ptr_ff[LIT_AW-1:0];
               probe_in    = PR_END_TAIL;
               state_in    = S_LIT_WAIT;
            end else begin
               state_in = S_CLASSIFY;
            end
         end

         S_CLASSIFY: begin
            priority if (head_ptr_ff + PTR_W'(1) == tail_ptr_ff) begin
               clause_status_in = ST_UNIT;
            end else if (head_ptr_ff == tail_ptr_ff) begin
               clause_status_in = ST_UNSAT;
            end else begin
               clause_status_in = ST_UNKNOWN;
            end
            state_in = S_UNIT;
         end

         S_UNIT: begin
            if (clause_status_ff == ST_UNIT && head_ptr_ff < count_ff) begin
               lit_rd_addr = head_ptr_ff[LIT_AW-1:0];
               probe_in    = PR_UNIT;
               state_in    = S_LIT_WAIT;
            end else begin
               ulit_in  = '0;
               state_in = S_REPLY;
            end
         end

         S_LIT_WAIT: begin
            lit_in = lit_rd_data;
            if (probe_ff == PR_UNIT) begin
               ulit_in  = lit_rd_data;
               state_in = S_REPLY;
            end else begin
               state_in = S_VAR_WAIT;
            end
         end

         S_VAR_WAIT: begin
            unique case (probe_ff)
               PR_HEAD: begin
                  if (!settled) begin
                     state_in = S_SCAN_TAIL;
                  end else begin
                     head_ptr_in = head_ptr_ff + PTR_W'(1);
                     if (lit_true) begin
                        clause_status_in = ST_SAT;
                        state_in         = S_UNIT;
                     end else begin
                        state_in = S_SCAN_HEAD;
                     end
                  end
               end
               PR_TAIL: begin
                  if (!settled) begin
                     state_in = S_END_HEAD;
                  end else begin
                     tail_ptr_in = tail_ptr_ff - PTR_W'(1);
                     if (lit_true) begin
                        clause_status_in = ST_SAT;
                        state_in         = S_UNIT;
                     end else begin
                        state_in = S_SCAN_TAIL;
                     end
                  end
               end
               PR_END_HEAD: begin
                  if (lit_true) begin
                     clause_status_in = ST_SAT;
                     state_in         = S_UNIT;
                  end else begin
                     state_in = S_END_TAIL;
                  end
               end
               PR_END_TAIL: begin
                  if (lit_true) begin
                     clause_status_in = ST_SAT;
                     state_in         = S_UNIT;
                  end else begin
                     state_in = S_CLASSIFY;
                  end
               end
               PR_UNIT: begin
                  state_in = S_REPLY;
               end
            endcase
         end

         S_REPLY: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               cmd_pop  = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         probe_ff         <= PR_HEAD;
         count_ff         <= '0;
         head_ptr_ff      <= '0;
         tail_ptr_ff      <= '0;
         clause_status_ff <= ST_UNKNOWN;
         var_valid_ff     <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         probe_ff         <= probe_in;
         count_ff         <= count_in;
         head_ptr_ff      <= head_ptr_in;
         tail_ptr_ff      <= tail_ptr_in;
         clause_status_ff <= clause_status_in;
         var_valid_ff     <= var_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lit_ff    <= lit_in;
      ulit_ff   <= ulit_in;
      vld_rd_ff <= vld_rd_in;
      if (rsp_load) begin
         rsp_status_ff <= clause_status_ff;
         rsp_ulit_ff   <= ulit_ff;
         rsp_head_ff   <= head_ptr_ff;
         rsp_tail_ff   <= tail_ptr_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_unit_literal = rsp_ulit_ff;
   assign rsp_head         = rsp_head_ff;
   assign rsp_tail         = rsp_tail_ff;

endmodule

`default_nettype wire

>>> rtl/sat_clause_head_tail_evaluator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Clause evaluator with head/tail watch pointers over one clause and a
// table of variable values and decision levels.
// Request channel (req_*): one item per operation: load literal, assign,
// unassign, update at a level, rollback of head, tail and status. An item
// is taken when req_valid is high and req_stall is low.
// Response channel (rsp_*): exactly one item per request, in order, showing
// status, unit literal, head and tail after the operation.
// A request enters a two-entry queue; an idle engine dispatches load,
// assign, unassign and rollback, fetches the unit literal when the status
// is unit, and replies. An update of a clause that is not yet satisfied or
// unsatisfied also makes at most MAX_LITERALS + 1 literal probes (the
// blocking literal is seen from both ends) and two end checks before the
// classify, unit fetch and reply steps. Each probe runs the serial chain
// clause store read -> variable table read, one literal at a time.
// One item is executed at a time; the queue keeps taking requests while
// the engine works on an item, until it is full.
// Reset: clause empty, pointers zero, status unknown, every variable
// unassigned (valid bits cleared at once, no clearing pass).
// A stalled response holds in the output register; the engine finishes the
// following item and waits, and the queue fills before req_stall rises.
module sat_clause_head_tail_evaluator_core
   import schte_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [OP_W-1:0]             req_operation,
   input  wire logic                        req_start_new,
   input  wire logic signed [LIT_W-1:0]     req_literal,
   input  wire logic [VAR_W-1:0]            req_variable,
   input  wire logic                        req_truth,
   input  wire logic [LEVEL_W-1:0]          req_level,
   input  wire logic [PTR_W-1:0]            req_head_in,
   input  wire logic [PTR_W-1:0]            req_tail_in,
   input  wire logic [STATUS_W-1:0]         req_status_in,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [STATUS_W-1:0]              rsp_status,
   output logic                             rsp_unit_valid,
   output logic signed [LIT_W-1:0]          rsp_unit_literal,
   output logic [PTR_W-1:0]                 rsp_head,
   output logic [PTR_W-1:0]                 rsp_tail
);

   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_pop;

   // Front: decode and queue requests
   schte_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_start_new (req_start_new),
      .req_literal   (req_literal),
      .req_variable  (req_variable),
      .req_truth     (req_truth),
      .req_level     (req_level),
      .req_head_in   (req_head_in),
      .req_tail_in   (req_tail_in),
      .req_status_in (req_status_in),
      .cmd           (cmd),
      .cmd_valid     (cmd_valid),
      .cmd_pop       (cmd_pop)
   );

   // Back: execute against clause store and variable table
   schte_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .cmd_valid        (cmd_valid),
      .cmd_pop          (cmd_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_unit_literal (rsp_unit_literal),
      .rsp_head         (rsp_head),
      .rsp_tail         (rsp_tail)
   );

   // Flag a unit clause alongside the status code
   assign rsp_unit_valid = (rsp_status == ST_UNIT);

endmodule

`default_nettype wire

>>> rtl/schte_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module schte_checker
   import schte_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        rsp_valid,
   input  wire logic                        rsp_stall,
   input  wire logic [STATUS_W-1:0]         rsp_status,
   input  wire logic                        rsp_unit_valid,
   input  wire logic signed [LIT_W-1:0]     rsp_unit_literal,
   input  wire logic [PTR_W-1:0]            rsp_head,
   input  wire logic [PTR_W-1:0]            rsp_tail
);

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_unit_literal) && $stable(rsp_head) && $stable(rsp_tail))
      else $error("stalled response changed");

   // Drop any response after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_unit_literal_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_unit_valid |-> rsp_unit_literal == '0)
      else $error("unit literal reported without unit status");

   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_head <= PTR_W'(MAX_LITERALS) && rsp_tail <= PTR_W'(MAX_LITERALS))
      else $error("pointer beyond clause capacity");

endmodule

bind sat_clause_head_tail_evaluator_core schte_checker u_schte_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_status       (rsp_status),
   .rsp_unit_valid   (rsp_unit_valid),
   .rsp_unit_literal (rsp_unit_literal),
   .rsp_head         (rsp_head),
   .rsp_tail         (rsp_tail)
);

`default_nettype wire

>>> dv/sat_clause_watch_checker.sv
`timescale 1ns / 1ps

module sat_clause_watch_checker
   import schte_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic                    req_stall,
   input  wire logic [OP_W-1:0]         req_operation,
   input  wire logic                    req_start_new,
   input  wire logic signed [LIT_W-1:0] req_literal,
   input  wire logic [VAR_W-1:0]        req_variable,
   input  wire logic                    req_truth,
   input  wire logic [LEVEL_W-1:0]      req_level,
   input  wire logic [PTR_W-1:0]        req_head_in,
   input  wire logic [PTR_W-1:0]        req_tail_in,
   input  wire logic [STATUS_W-1:0]     req_status_in,
   input  wire logic                    rsp_valid,
   input  wire logic                    rsp_stall,
   input  wire logic [STATUS_W-1:0]     rsp_status,
   input  wire logic                    rsp_unit_valid,
   input  wire logic signed [LIT_W-1:0] rsp_unit_literal,
   input  wire logic [PTR_W-1:0]        rsp_head,
   input  wire logic [PTR_W-1:0]        rsp_tail,
   output int                           mismatch_count,
   output int                           pending_count
);

   // Variable value encoding
   localparam logic [1:0] VAL_FREE  = 2'd0;
   localparam logic [1:0] VAL_TRUE  = 2'd1;
   localparam logic [1:0] VAL_FALSE = 2'd2;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                unit_valid;
      logic [LIT_W-1:0]    unit_literal;
      logic [PTR_W-1:0]    head;
      logic [PTR_W-1:0]    tail;
   } clause_view_type;

   logic signed [LIT_W-1:0] clause_lits [MAX_LITERALS];
   int                      lit_count;
   int                      head_ptr;
   int                      tail_ptr;
   logic [STATUS_W-1:0]     clause_st;
   logic [1:0]              var_val [MAX_VARIABLES];
   int                      var_lvl [MAX_VARIABLES];

   clause_view_type expected_views [$];
   int              errors = 0;

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
   end

   function automatic void clear_clause_model();
      for (int i = 0; i < MAX_LITERALS; i++) clause_lits[i] = '0;
      for (int i = 0; i < MAX_VARIABLES; i++) begin
         var_val[i] = VAL_FREE;
         var_lvl[i] = -1;
      end
      lit_count = 0;
      head_ptr  = 0;
      tail_ptr  = 0;
      clause_st = ST_UNKNOWN;
   endfunction

   function automatic int var_index(input logic signed [LIT_W-1:0] lit);
      int v;
      v = lit;
      return (v < 0) ? -v : v;
   endfunction

   // Variables past the table read as unassigned and undecided.
   function automatic bit lit_true(input logic signed [LIT_W-1:0] lit);
      int         v;
      logic [1:0] val;
      v   = var_index(lit);
      val = (v < MAX_VARIABLES) ? var_val[v] : VAL_FREE;
      return (lit > 0 && val == VAL_TRUE) || (lit < 0 && val == VAL_FALSE);
   endfunction

   function automatic bit lit_decided(input logic signed [LIT_W-1:0] lit, input int lvl);
      int v;
      int d;
      v = var_index(lit);
      d = (v < MAX_VARIABLES) ? var_lvl[v] : -1;
      return d != -1 && d <= lvl;
   endfunction

   function automatic void walk_clause(input int lvl);
      if (clause_st == ST_SAT || clause_st == ST_UNSAT) return;
      while (head_ptr < tail_ptr && lit_decided(clause_lits[head_ptr], lvl)) begin
         head_ptr++;
         if (lit_true(clause_lits[head_ptr-1])) begin
            clause_st = ST_SAT;
            return;
         end
      end
      while (head_ptr < tail_ptr && lit_decided(clause_lits[tail_ptr-1], lvl)) begin
         tail_ptr--;
         if (lit_true(clause_lits[tail_ptr])) begin
            clause_st = ST_SAT;
            return;
         end
      end
      if (head_ptr > 0 && lit_true(clause_lits[head_ptr-1]))
         clause_st = ST_SAT;
      else if (tail_ptr < lit_count && lit_true(clause_lits[tail_ptr]))
         clause_st = ST_SAT;
      else if (head_ptr + 1 == tail_ptr)
         clause_st = ST_UNIT;
      else if (head_ptr == tail_ptr)
         clause_st = ST_UNSAT;
      else
         clause_st = ST_UNKNOWN;
   endfunction

   function automatic clause_view_type advance_clause(
      input logic [OP_W-1:0]         op,
      input logic                    start_new,
      input logic signed [LIT_W-1:0] lit,
      input logic [VAR_W-1:0]        var_idx,
      input logic                    truth,
      input logic [LEVEL_W-1:0]      lvl,
      input logic [PTR_W-1:0]        h_in,
      input logic [PTR_W-1:0]        t_in,
      input logic [STATUS_W-1:0]     s_in
   );
      clause_view_type view;
      case (op)
         OP_LOAD: begin
            if (start_new) lit_count = 0;
            // drop the literal when the clause is full
            if (lit_count < MAX_LITERALS) begin
               clause_lits[lit_count] = lit;
               lit_count++;
               head_ptr  = 0;
               tail_ptr  = lit_count;
               clause_st = ST_UNKNOWN;
            end
         end
         OP_ASSIGN: begin
            if (var_idx < MAX_VARIABLES) begin
               var_val[var_idx] = truth ? VAL_TRUE : VAL_FALSE;
               var_lvl[var_idx] = lvl;
            end
         end
         OP_UNASSIGN: begin
            if (var_idx < MAX_VARIABLES) begin
               var_val[var_idx] = VAL_FREE;
               var_lvl[var_idx] = -1;
            end
         end
         OP_UPDATE: walk_clause(lvl);
         OP_ROLLBACK: begin
            head_ptr  = (h_in > lit_count) ? lit_count : h_in;
            tail_ptr  = (t_in > lit_count) ? lit_count : t_in;
            clause_st = s_in;
         end
         default: ;
      endcase
      view.status       = clause_st;
      view.unit_valid   = (clause_st == ST_UNIT);
      view.unit_literal = (clause_st == ST_UNIT && head_ptr < lit_count) ?
                          clause_lits[head_ptr] : '0;
      view.head         = PTR_W'(head_ptr);
      view.tail         = PTR_W'(tail_ptr);
      return view;
   endfunction

   always @(posedge clock) begin
      clause_view_type want;
      clause_view_type got;
      if (reset) begin
         clear_clause_model();
         expected_views.delete();
      end else begin
         if (req_valid && !req_stall)
            expected_views.insert(expected_views.size(),
               advance_clause(req_operation, req_start_new, req_literal, req_variable,
                  req_truth, req_level, req_head_in, req_tail_in, req_status_in));
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_status, rsp_unit_valid, rsp_unit_literal, rsp_head, rsp_tail};
            if (expected_views.size() == 0) begin
               if (errors < 10)
                  $display("%0t: result with nothing outstanding: %s%0d %s%0b %s%0d %s%0d %s%0d",
                     $realtime, "status=", got.status, "unit=", got.unit_valid,
                     "lit=", $signed(got.unit_literal), "head=", got.head,
                     "tail=", got.tail);
               errors++;
            end else begin
               want = expected_views.pop_front();
               if (want !== got) begin
                  if (errors < 10) begin
                     $write("%0t: expected status=%0d unit=%0b lit=%0d head=%0d tail=%0d,",
                        $realtime, want.status, want.unit_valid,
                        $signed(want.unit_literal), want.head, want.tail);
                     $display(" got status=%0d unit=%0b lit=%0d head=%0d tail=%0d",
                        got.status, got.unit_valid, $signed(got.unit_literal),
                        got.head, got.tail);
                  end
                  errors++;
               end
            end
         end
      end
      mismatch_count <= errors;
      pending_count  <= expected_views.size();
   end

endmodule

>>> dv/sat_clause_head_tail_evaluator_core_tb.sv
`timescale 1ns / 1ps

module sat_clause_head_tail_evaluator_core_tb;
   import schte_pkg::*;

   // Opcodes the block does not use; they must leave the state alone.
   localparam logic [OP_W-1:0] OP_RESERVED_FIRST = 3'd5;
   localparam logic [OP_W-1:0] OP_RESERVED_LAST  = 3'd7;

   localparam int ITEM_TARGET = 950;
   // Allow a wide margin on top of the longest update.
   localparam int STALL_LIMIT = 3000;
   localparam int DRAIN_CYCLES = 80;

   typedef struct packed {
      logic [OP_W-1:0]         op;
      logic                    start_new;
      logic signed [LIT_W-1:0] literal;
      logic [VAR_W-1:0]        var_idx;
      logic                    truth;
      logic [LEVEL_W-1:0]      level;
      logic [PTR_W-1:0]        head_in;
      logic [PTR_W-1:0]        tail_in;
      logic [STATUS_W-1:0]     status_in;
   } clause_cmd_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [OP_W-1:0]         req_operation = '0;
   logic                    req_start_new = 1'b0;
   logic signed [LIT_W-1:0] req_literal = '0;
   logic [VAR_W-1:0]        req_variable = '0;
   logic                    req_truth = 1'b0;
   logic [LEVEL_W-1:0]      req_level = '0;
   logic [PTR_W-1:0]        req_head_in = '0;
   logic [PTR_W-1:0]        req_tail_in = '0;
   logic [STATUS_W-1:0]     req_status_in = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [STATUS_W-1:0]     rsp_status;
   logic                    rsp_unit_valid;
   logic signed [LIT_W-1:0] rsp_unit_literal;
   logic [PTR_W-1:0]        rsp_head;
   logic [PTR_W-1:0]        rsp_tail;

   int mismatches;
   int pending_results;
   int useful_items = 0;
   int idle_cycles = 0;
   // When set, neither side inserts bubbles or back-pressure.
   bit calm = 1'b0;

   always #10 clock = ~clock;

   sat_clause_head_tail_evaluator_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_start_new    (req_start_new),
      .req_literal      (req_literal),
      .req_variable     (req_variable),
      .req_truth        (req_truth),
      .req_level        (req_level),
      .req_head_in      (req_head_in),
      .req_tail_in      (req_tail_in),
      .req_status_in    (req_status_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_unit_valid   (rsp_unit_valid),
      .rsp_unit_literal (rsp_unit_literal),
      .rsp_head         (rsp_head),
      .rsp_tail         (rsp_tail)
   );

   sat_clause_watch_checker u_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_start_new    (req_start_new),
      .req_literal      (req_literal),
      .req_variable     (req_variable),
      .req_truth        (req_truth),
      .req_level        (req_level),
      .req_head_in      (req_head_in),
      .req_tail_in      (req_tail_in),
      .req_status_in    (req_status_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_unit_valid   (rsp_unit_valid),
      .rsp_unit_literal (rsp_unit_literal),
      .rsp_head         (rsp_head),
      .rsp_tail         (rsp_tail),
      .mismatch_count   (mismatches),
      .pending_count    (pending_results)
   );

   // Back-pressure on the result side: stall with a chance of about 31 in 100,
   // except during the calm stretch.
   always @(posedge clock) begin
      rsp_stall <= !reset && !calm && ($urandom_range(99) < 31);
   end

   // Watchdog: end the run if nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // Fill every field with random bits so that fields the opcode ignores
   // still toggle; callers then override the fields that matter.
   function automatic clause_cmd_type blank_cmd(input logic [OP_W-1:0] op);
      clause_cmd_type c;
      c.op        = op;
      c.start_new = $urandom_range(1);
      c.literal   = LIT_W'($urandom_range((1 << LIT_W) - 1));
      c.var_idx   = VAR_W'($urandom_range((1 << VAR_W) - 1));
      c.truth     = $urandom_range(1);
      c.level     = LEVEL_W'($urandom_range((1 << LEVEL_W) - 1));
      c.head_in   = PTR_W'($urandom_range((1 << PTR_W) - 1));
      c.tail_in   = PTR_W'($urandom_range((1 << PTR_W) - 1));
      c.status_in = STATUS_W'($urandom_range((1 << STATUS_W) - 1));
      return c;
   endfunction

   // Present one item, with random bubbles ahead of it, and hold it until
   // the block takes it. Valid is written once per edge so a back-to-back
   // item keeps it high without a glitch.
   task automatic issue(input clause_cmd_type c);
      while (!calm && $urandom_range(99) < 31) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= c.op;
      req_start_new <= c.start_new;
      req_literal   <= c.literal;
      req_variable  <= c.var_idx;
      req_truth     <= c.truth;
      req_level     <= c.level;
      req_head_in   <= c.head_in;
      req_tail_in   <= c.tail_in;
      req_status_in <= c.status_in;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (c.op <= OP_ROLLBACK) useful_items++;
   endtask

   task automatic do_load(input bit first, input int lit);
      clause_cmd_type c;
      c           = blank_cmd(OP_LOAD);
      c.start_new = first;
      c.literal   = LIT_W'(lit);
      issue(c);
   endtask

   task automatic do_assign(input int v, input bit t, input int lvl);
      clause_cmd_type c;
      c         = blank_cmd(OP_ASSIGN);
      c.var_idx = VAR_W'(v);
      c.truth   = t;
      c.level   = LEVEL_W'(lvl);
      issue(c);
   endtask

   task automatic do_unassign(input int v);
      clause_cmd_type c;
      c         = blank_cmd(OP_UNASSIGN);
      c.var_idx = VAR_W'(v);
      issue(c);
   endtask

   task automatic do_update(input int lvl);
      clause_cmd_type c;
      c       = blank_cmd(OP_UPDATE);
      c.level = LEVEL_W'(lvl);
      issue(c);
   endtask

   task automatic do_rollback(input int h, input int t, input logic [STATUS_W-1:0] s);
      clause_cmd_type c;
      c           = blank_cmd(OP_ROLLBACK);
      c.head_in   = PTR_W'(h);
      c.tail_in   = PTR_W'(t);
      c.status_in = s;
      issue(c);
   endtask

   initial begin
      int n;
      int pool;
      int lvl;
      int v;
      int clause_q [$];

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part ----
      // Update on an empty clause: head meets tail at once, so unsatisfied.
      do_update(0);
      // Out-of-range rollback saturates both pointers to the empty clause.
      do_rollback(31, 31, ST_UNKNOWN);
      // Extremes of the literal, including zero and the pattern that maps
      // to a variable past the table.
      do_load(1, -256);
      do_load(0, -255);
      do_load(0, 0);
      do_load(0, 3);
      do_load(0, 255);
      do_assign(255, 1'b1, 255);
      do_assign(0, 1'b0, 255);
      do_assign(3, 1'b0, 5);
      // Head blocks on the undecided first literal, tail on a deep level.
      do_update(4);
      // Restore pointers, then walk the head up to the tail; the literal
      // just past the tail is true, so the clause is satisfied.
      do_rollback(1, 4, ST_UNKNOWN);
      do_update(255);
      // A settled clause ignores further updates.
      do_update(255);
      // Head past tail and past the clause with a unit status: reports a
      // zero unit literal; the following update only looks at the ends.
      do_rollback(20, 2, ST_UNIT);
      do_update(7);
      do_unassign(255);
      do_unassign(0);
      for (int op = OP_RESERVED_FIRST; op <= OP_RESERVED_LAST; op++)
         issue(blank_cmd(OP_W'(op)));
      // Two-literal clause: first goes false, second is the unit, then
      // falsify it too for an unsatisfied clause.
      do_load(1, 1);
      do_load(0, 2);
      do_assign(1, 1'b0, 1);
      do_update(1);
      do_assign(2, 1'b0, 1);
      do_update(1);

      // ---- random part ----
      // Mostly well-formed episodes: build a sorted clause over a small
      // variable pool, then run a trail of assigns, updates, unassigns and
      // rollbacks. About one round in eight is raw noise.
      while (useful_items < ITEM_TARGET) begin
         calm = (useful_items >= 400 && useful_items < 560);
         if ($urandom_range(7) == 0) begin
            repeat ($urandom_range(1, 6)) issue(blank_cmd(OP_W'($urandom_range((1 << OP_W) - 1))));
         end else begin
            // Occasionally overfill the clause so extra loads are dropped.
            n    = ($urandom_range(5) == 0) ? $urandom_range(9, MAX_LITERALS + 3)
                                            : $urandom_range(1, 8);
            pool = $urandom_range(3, 20);
            clause_q.delete();
            for (int i = 0; i < n; i++) begin
               v = $urandom_range(0, pool);
               if ($urandom_range(31) == 0)
                  clause_q.insert(clause_q.size(), -(1 << (LIT_W - 1)));
               else
                  clause_q.insert(clause_q.size(), $urandom_range(1) ? v : -v);
            end
            clause_q.sort();
            for (int i = 0; i < n; i++) do_load(i == 0, clause_q[i]);
            // Free a few leftovers from the previous trail.
            repeat ($urandom_range(0, 3)) do_unassign($urandom_range(0, pool));
            lvl = 0;
            repeat ($urandom_range(4, 14)) begin
               case ($urandom_range(9))
                  0, 1, 2, 3: begin
                     do_assign($urandom_range(0, pool), $urandom_range(1), lvl);
                     if (lvl < 40) lvl += $urandom_range(1);
                  end
                  4, 5, 6: do_update(($urandom_range(9) == 0) ? 255 : $urandom_range(0, lvl + 1));
                  7: do_unassign($urandom_range(0, pool));
                  8: do_rollback(($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(0, n),
                                 ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(0, n),
                                 STATUS_W'($urandom_range(3)));
                  default: do_update(lvl);
               endcase
            end
         end
      end
      calm = 1'b0;

      // ---- drain ----
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_results == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
